>>> rtl/mlee_pkg.sv
package mlee_pkg;

  localparam int SLOPE_W = 32;
  localparam int ICPT_W = 48;
  localparam int VALUE_W = 64;
  localparam int MA_W = 49;
  localparam int MB_W = 33;
  localparam int PROD_W = 82;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic done;
    logic signed [PROD_W-1:0] product;
  } mul_rsp_t;

endpackage

>>> rtl/min_line_envelope_engine_unit.sv
// An add tests the tail lines against the new line one at a time, and a query
// searches the breakpoints by bisection. One memory read port and a shared
// multiplier, busy with one product at a time, carry every breakpoint test.
// One word is handled at a time; busy stays high until its result strobes, and a
// query on an empty store answers in the next cycle without raising busy.
// Synchronous reset empties the store at once; the receiver cannot stall.
module min_line_envelope_engine_unit #(
  parameter int MAX_LINES = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic operation,
  input  logic signed [mlee_pkg::SLOPE_W-1:0] line_slope,
  input  logic signed [mlee_pkg::ICPT_W-1:0] line_intercept,
  input  logic signed [mlee_pkg::SLOPE_W-1:0] query_point,
  output logic done,
  output logic signed [mlee_pkg::VALUE_W-1:0] min_value,
  output logic [1:0] status
);
  import mlee_pkg::*;

  localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CW = $clog2(MAX_LINES + 1);
  localparam int IW = CW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_WAIT, S_LAST, S_PCHK, S_RB, S_RA, S_MGO, S_MWAIT, S_LHS, S_CMP,
    S_FULL, S_QCHK, S_QR0, S_QR1, S_QCMP, S_QPICK, S_QVAL
  } state_t;

  state_t state, ret;
  logic signed [SLOPE_W-1:0] ms, qx, am, bm, s0;
  logic signed [ICPT_W-1:0] bs, ab, bb, i0;
  logic signed [MA_W-1:0] nb, opa;
  logic signed [MB_W-1:0] opb;
  logic signed [PROD_W-1:0] lhs;
  logic [CW-1:0] n, count, pick, n_m1, n_m2;
  logic bvalid;
  logic signed [IW-1:0] lo, hi, mid;
  logic signed [IW:0] lohi;
  logic [AW-1:0] rd_addr;
  logic [SLOPE_W+ICPT_W-1:0] rd_data;
  logic [SLOPE_W+ICPT_W-1:0] mem [MAX_LINES];
  logic signed [SLOPE_W-1:0] rd_s;
  logic signed [ICPT_W-1:0] rd_i;
  logic wr_en;
  logic mul_go;
  mul_rsp_t mrsp;

  assign rd_s = rd_data[SLOPE_W+ICPT_W-1:ICPT_W];
  assign rd_i = rd_data[ICPT_W-1:0];
  assign n_m1 = n - CW'(1);
  assign n_m2 = n - CW'(2);
  assign lohi = (IW+1)'(lo) + (IW+1)'(hi);
  assign mid = IW'(lohi >>> 1);
  assign busy = (state != S_IDLE);
  assign mul_go = (state == S_MGO);
  assign wr_en = (state == S_FULL) && (n != CW'(MAX_LINES));

  mlee_mul u_mul (
    .clk(clk),
    .rst(rst),
    .go(mul_go),
    .a(opa),
    .b(opb),
    .rsp(mrsp)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[n[AW-1:0]] <= {ms, bs};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ms <= line_slope;
            bs <= line_intercept;
            qx <= query_point;
            if (operation == OP_ADD) begin
              n <= count;
              bvalid <= 1'b0;
              if (count == '0) begin
                state <= S_FULL;
              end else begin
                rd_addr <= AW'(count - CW'(1));
                ret <= S_LAST;
                state <= S_RD_WAIT;
              end
            end else if (count == '0) begin
              done <= 1'b1;
              min_value <= '0;
              status <= ST_EMPTY;
            end else begin
              lo <= '0;
              hi <= IW'(count) - IW'(2);
              pick <= count - CW'(1);
              state <= S_QCHK;
            end
          end
        end
        S_RD_WAIT: state <= ret;
        S_LAST: begin
          if (ms > rd_s) begin
            done <= 1'b1;
            min_value <= '0;
            status <= ST_ORDER;
            state <= S_IDLE;
          end else if (ms == rd_s) begin
            if (bs >= rd_i) begin
              done <= 1'b1;
              min_value <= '0;
              status <= ST_OK;
              state <= S_IDLE;
            end else begin
              n <= n_m1;
              state <= S_PCHK;
            end
          end else begin
            bm <= rd_s;
            bb <= rd_i;
            bvalid <= 1'b1;
            state <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (n < CW'(2)) begin
            state <= S_FULL;
          end else if (!bvalid) begin
            rd_addr <= n_m1[AW-1:0];
            ret <= S_RB;
            state <= S_RD_WAIT;
          end else begin
            rd_addr <= n_m2[AW-1:0];
            ret <= S_RA;
            state <= S_RD_WAIT;
          end
        end
        S_RB: begin
          bm <= rd_s;
          bb <= rd_i;
          bvalid <= 1'b1;
          state <= S_PCHK;
        end
        S_RA: begin
          am <= rd_s;
          ab <= rd_i;
          opa <= MA_W'(bb) - MA_W'(rd_i);
          opb <= MB_W'(bm) - MB_W'(ms);
          ret <= S_LHS;
          state <= S_MGO;
        end
        S_MGO: state <= S_MWAIT;
        S_MWAIT: begin
          if (mrsp.done) begin
            state <= ret;
          end
        end
        S_LHS: begin
          lhs <= mrsp.product;
          opa <= MA_W'(bs) - MA_W'(bb);
          opb <= MB_W'(am) - MB_W'(bm);
          ret <= S_CMP;
          state <= S_MGO;
        end
        S_CMP: begin
          if (lhs >= mrsp.product) begin
            n <= n_m1;
            bm <= am;
            bb <= ab;
            state <= S_PCHK;
          end else begin
            state <= S_FULL;
          end
        end
        S_FULL: begin
          done <= 1'b1;
          min_value <= '0;
          state <= S_IDLE;
          if (n == CW'(MAX_LINES)) begin
            status <= ST_FULL;
          end else begin
            status <= ST_OK;
            count <= n + CW'(1);
          end
        end
        S_QCHK: begin
          if (lo <= hi) begin
            rd_addr <= AW'(mid);
            ret <= S_QR0;
          end else begin
            rd_addr <= AW'(pick);
            ret <= S_QPICK;
          end
          state <= S_RD_WAIT;
        end
        S_QR0: begin
          s0 <= rd_s;
          i0 <= rd_i;
          rd_addr <= AW'(mid + IW'(1));
          ret <= S_QR1;
          state <= S_RD_WAIT;
        end
        S_QR1: begin
          nb <= MA_W'(rd_i) - MA_W'(i0);
          opa <= MA_W'(qx);
          opb <= MB_W'(s0) - MB_W'(rd_s);
          ret <= S_QCMP;
          state <= S_MGO;
        end
        S_QCMP: begin
          if (PROD_W'(nb) >= mrsp.product) begin
            pick <= CW'(mid);
            hi <= mid - IW'(1);
          end else begin
            lo <= mid + IW'(1);
          end
          state <= S_QCHK;
        end
        S_QPICK: begin
          i0 <= rd_i;
          opa <= MA_W'(rd_s);
          opb <= MB_W'(qx);
          ret <= S_QVAL;
          state <= S_MGO;
        end
        S_QVAL: begin
          done <= 1'b1;
          min_value <= mrsp.product[VALUE_W-1:0] + VALUE_W'(i0);
          status <= ST_OK;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe repeated");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_LINES))
    else $error("line count beyond store depth");
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !(operation == OP_QUERY && count == '0)) |=> busy)
    else $error("accepted word did not raise busy");
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> state == S_MWAIT)
    else $error("multiplier finished outside a wait");

endmodule

>>> rtl/mlee_mul.sv
module mlee_mul (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  logic signed [mlee_pkg::MA_W-1:0] a,
  input  logic signed [mlee_pkg::MB_W-1:0] b,
  output mlee_pkg::mul_rsp_t rsp
);
  import mlee_pkg::*;

  typedef enum logic [1:0] {P_IDLE, P_LO, P_HI, P_SUM} phase_t;

  phase_t phase;
  logic done;
  logic signed [MA_W-1:0] ar;
  logic signed [MB_W-1:0] br;
  logic signed [2*MB_W-1:0] p;
  logic signed [PROD_W-1:0] acc;
  logic signed [MB_W-1:0] mx;

  // The wide operand is split into an unsigned low 32 bits and a signed high 17-bit part.
  assign mx = (phase == P_LO) ? $signed({1'b0, ar[31:0]})
                              : $signed({{(MB_W-17){ar[MA_W-1]}}, ar[MA_W-1:32]});

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (go) begin
            ar <= a;
            br <= b;
            phase <= P_LO;
          end
        end
        P_LO: begin
          p <= (2*MB_W)'(mx) * (2*MB_W)'(br);
          phase <= P_HI;
        end
        P_HI: begin
          acc <= PROD_W'(p);
          p <= (2*MB_W)'(mx) * (2*MB_W)'(br);
          phase <= P_SUM;
        end
        P_SUM: begin
          acc <= acc + (PROD_W'(p) <<< 32);
          done <= 1'b1;
          phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.product = acc;

endmodule
